// File: sv/swm_pkg.sv
// Shared widths, control structs and sequencer states for the sliding-window median filter.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 48;
   localparam int CFG_W      = 7;
   localparam int RSP_DATA_W = SAMPLE_W + SUM_W;

   // Broadcast to every cell of the sorted row.
   typedef struct packed {
      logic                load;
      logic                full;
      logic [SAMPLE_W-1:0] sample;
   } row_ctl_type;

   // Per-cell position flags, derived from the cell index.
   typedef struct packed {
      logic live;     // slot holds an entry of the window after the removal step
      logic beyond;   // slot lies past the configured window length
   } cell_pos_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM
   } seq_state_type;

endpackage

// File: sv/swm_cell.sv
// One slot of the sorted row: value, age and the removal flag that drives the left shift.
`timescale 1ns / 1ps

module swm_cell #(
   parameter int AGE_W = 6
) (
   input  logic                          clock,
   input  swm_pkg::row_ctl_type          ctl,
   input  swm_pkg::cell_pos_type         pos,
   input  logic [swm_pkg::SAMPLE_W-1:0]  old_val,
   input  logic [swm_pkg::SAMPLE_W-1:0]  right_val,
   input  logic [AGE_W-1:0]              right_age,
   input  logic [swm_pkg::SAMPLE_W-1:0]  left_val,
   input  logic [AGE_W-1:0]              left_age,
   input  logic                          left_le,
   output logic [swm_pkg::SAMPLE_W-1:0]  val_o,
   output logic [AGE_W-1:0]              age_o,
   output logic [swm_pkg::SAMPLE_W-1:0]  shift_val,
   output logic [AGE_W-1:0]              shift_age,
   output logic                          le_o
);

   logic [swm_pkg::SAMPLE_W-1:0] val_ff, val_in;
   logic [AGE_W-1:0]             age_ff, age_in;
   logic                         rm_ff, rm_in;
   logic                         rm_eff;

   // When the window is full and the oldest entry sits at or left of this slot, the slot
   // takes its right neighbor's entry to close the gap before the new sample is placed.
   assign rm_eff    = ctl.full & rm_ff;
   assign shift_val = rm_eff ? right_val : val_ff;
   assign shift_age = rm_eff ? right_age : age_ff;
   assign le_o      = pos.live && (shift_val <= ctl.sample);

   // Equal values sit oldest first, so the oldest entry is the leftmost copy of
   // its value and every slot from it on holds a value no smaller.
   assign rm_in = pos.beyond || (val_ff >= old_val);

   always_comb begin
      val_in = val_ff;
      age_in = age_ff;
      if (ctl.load) begin
         if (le_o) begin
            val_in = shift_val;
            age_in = shift_age + AGE_W'(1);
         end else if (left_le) begin
            val_in = ctl.sample;
            age_in = '0;
         end else begin
            val_in = left_val;
            age_in = left_age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      age_ff <= age_in;
      rm_ff  <= rm_in;
   end

   assign val_o = val_ff;
   assign age_o = age_ff;

endmodule

// File: sv/swm_chain.sv
// Row of sorted cells with registered taps for the median and the oldest value.
`timescale 1ns / 1ps

module swm_chain #(
   parameter int WINDOW_MAX = 64,
   parameter int LEN_W      = 7,
   parameter int AGE_W      = 6
) (
   input  logic                          clock,
   input  swm_pkg::row_ctl_type          ctl,
   input  logic [LEN_W-1:0]              lim,
   input  logic [LEN_W-1:0]              klen,
   input  logic [AGE_W-1:0]              old_age,
   input  logic [AGE_W-1:0]              mid,
   output logic [swm_pkg::SAMPLE_W-1:0]  med_val
);

   logic [swm_pkg::SAMPLE_W-1:0] val_w   [WINDOW_MAX];
   logic [AGE_W-1:0]             age_w   [WINDOW_MAX];
   logic [swm_pkg::SAMPLE_W-1:0] shv_w   [WINDOW_MAX];
   logic [AGE_W-1:0]             sha_w   [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]        le_w;
   logic [WINDOW_MAX-1:0]        beyond_w;

   logic [swm_pkg::SAMPLE_W-1:0] med_ff, med_in;
   logic [swm_pkg::SAMPLE_W-1:0] old_ff, old_in;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_pkg::cell_pos_type        pos;
      logic [swm_pkg::SAMPLE_W-1:0] rv, lv;
      logic [AGE_W-1:0]             ra, la;
      logic                         ll;

      assign beyond_w[i] = LEN_W'(i) >= klen;
      assign pos.live    = LEN_W'(i) < lim;
      assign pos.beyond  = beyond_w[i];

      if (i == WINDOW_MAX - 1) begin : g_right_end
         assign rv = val_w[i];
         assign ra = age_w[i];
      end else begin : g_right
         assign rv = val_w[i+1];
         assign ra = age_w[i+1];
      end

      if (i == 0) begin : g_left_end
         assign lv = '0;
         assign la = '0;
         assign ll = 1'b1;
      end else begin : g_left
         assign lv = shv_w[i-1];
         assign la = sha_w[i-1];
         assign ll = le_w[i-1];
      end

      swm_cell #(
         .AGE_W (AGE_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .pos       (pos),
         .old_val   (old_ff),
         .right_val (rv),
         .right_age (ra),
         .left_val  (lv),
         .left_age  (la),
         .left_le   (ll),
         .val_o     (val_w[i]),
         .age_o     (age_w[i]),
         .shift_val (shv_w[i]),
         .shift_age (sha_w[i]),
         .le_o      (le_w[i])
      );
   end

   // One-hot select over the row; at most one slot matches each tap.
   always_comb begin
      med_in = '0;
      old_in = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         if (AGE_W'(i) == mid) begin
            med_in = med_in | val_w[i];
         end
         if (!beyond_w[i] && (age_w[i] == old_age)) begin
            old_in = old_in | val_w[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      med_ff <= med_in;
      old_ff <= old_in;
   end

   assign med_val = med_ff;

endmodule

// File: sv/sliding_window_median_top.sv
// Top level of the sliding-window median filter: sequencer, window length, fill count and sum.
//
//   channel  | direction | beat contents
//   ---------+-----------+------------------------------------------------------
//   req_     | in        | tdata: sample; tlast: last sample of the sequence
//   rsp_     | out       | tdata: median, median_sum; tuser: median_valid; tlast: sum_final
//   csr_     | in        | data: window_len (restarts the window; taken between samples)
//
// Each sample is handled in order: the accepting edge shifts the sorted cell row, the READ
// state registers the median and oldest-value taps, and the SUM state refreshes the cells'
// removal flags and folds the median into the saturating sum.
// A result register lets the next sample enter while a result waits; the SUM state
// holds as long as that register is still occupied and its beat is not taken.
// Reset is synchronous: window length 1, empty window, zero sum.
`timescale 1ns / 1ps

module sliding_window_median_top #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swm_pkg::SAMPLE_W-1:0]    req_tdata,   // [15:0] sample
   input  logic                            req_tlast,

   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swm_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [15:0] median, [63:16] median_sum
   output logic                            rsp_tuser,   // [0] median_valid
   output logic                            rsp_tlast,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [swm_pkg::CFG_W-1:0]       csr_data
);

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_W = (LEN_W > swm_pkg::CFG_W) ? LEN_W : swm_pkg::CFG_W;

   swm_pkg::seq_state_type state_ff, state_in;

   logic [LEN_W-1:0]             klen_ff, klen_in;
   logic [LEN_W-1:0]             fill_ff, fill_in;
   logic [swm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                         valid_ff, valid_in;
   logic                         last_ff, last_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [swm_pkg::SAMPLE_W-1:0] rsp_med_ff, rsp_med_in;
   logic [swm_pkg::SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic                         rsp_mv_ff, rsp_mv_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         load;
   logic                         out_load;
   logic                         full;
   logic [LEN_W-1:0]             fill_step;
   logic [LEN_W-1:0]             lim;
   logic [LEN_W-1:0]             klen_m1;
   logic [CMP_W-1:0]             cfg_ext;
   swm_pkg::row_ctl_type         row_ctl;
   logic [swm_pkg::SAMPLE_W-1:0] med_val;
   logic [swm_pkg::SUM_W:0]      sum_ext;
   logic [swm_pkg::SUM_W-1:0]    sum_next;

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      load       = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         swm_pkg::ST_IDLE: begin
            // A window-length beat takes precedence over a waiting sample.
            req_tready = !csr_valid;
            load       = req_tvalid && !csr_valid;
            if (load) begin
               state_in = swm_pkg::ST_READ;
            end
         end
         swm_pkg::ST_READ: begin
            state_in = swm_pkg::ST_SUM;
         end
         swm_pkg::ST_SUM: begin
            out_load = !rsp_valid_ff || rsp_tready;
            if (out_load) begin
               state_in = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- window control
   assign csr_ready = (state_ff == swm_pkg::ST_IDLE);
   assign cfg_ext   = CMP_W'(csr_data);
   assign klen_m1   = klen_ff - LEN_W'(1);
   assign full      = (fill_ff == klen_ff);
   assign fill_step = full ? fill_ff : fill_ff + LEN_W'(1);
   // Once full, the row holds one entry fewer after the oldest one drops out.
   assign lim       = full ? klen_m1 : fill_ff;

   always_comb begin
      klen_in  = klen_ff;
      fill_in  = fill_ff;
      valid_in = valid_ff;
      last_in  = last_ff;
      if (csr_valid && csr_ready) begin
         if (cfg_ext == '0) begin
            klen_in = LEN_W'(1);
         end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
            klen_in = LEN_W'(WINDOW_MAX);
         end else begin
            klen_in = LEN_W'(cfg_ext);
         end
         fill_in = '0;
      end else if (load) begin
         valid_in = (fill_step == klen_ff);
         last_in  = req_tlast;
         fill_in  = req_tlast ? '0 : fill_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= LEN_W'(1);
         fill_ff <= '0;
      end else begin
         klen_ff <= klen_in;
         fill_ff <= fill_in;
      end
      valid_ff <= valid_in;
      last_ff  <= last_in;
   end

   // ---------------------------------------------------------------- sorted row
   assign row_ctl.load   = load;
   assign row_ctl.full   = full;
   assign row_ctl.sample = req_tdata;

   swm_chain #(
      .WINDOW_MAX (WINDOW_MAX),
      .LEN_W      (LEN_W),
      .AGE_W      (AGE_W)
   ) u_chain (
      .clock   (clock),
      .ctl     (row_ctl),
      .lim     (lim),
      .klen    (klen_ff),
      .old_age (AGE_W'(klen_m1)),
      .mid     (AGE_W'(klen_m1 >> 1)),
      .med_val (med_val)
   );

   // ---------------------------------------------------------------- sum and result beat
   assign sum_ext  = {1'b0, sum_ff}
                   + {{(swm_pkg::SUM_W + 1 - swm_pkg::SAMPLE_W){1'b0}}, med_val};
   assign sum_next = !valid_ff ? sum_ff : (sum_ext[swm_pkg::SUM_W] ? '1 :
                                           sum_ext[swm_pkg::SUM_W-1:0]);

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_med_in   = valid_ff ? med_val : '0;
         rsp_sum_in   = sum_next;
         rsp_mv_in    = valid_ff;
         rsp_last_in  = last_ff;
         sum_in       = last_ff ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_med_ff  <= rsp_med_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_sum_ff, rsp_med_ff};
   assign rsp_tuser  = rsp_mv_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= klen_ff)
      else $error("fill count exceeds window length");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(out_load && rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while its beat waits");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == swm_pkg::ST_READ))
      else $error("accepted sample did not start the tap read");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |=> (sum_ff == '0))
      else $error("sum not cleared after a closing beat");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the sliding-window median filter with its saturating median sum.
`timescale 1ns / 1ps

module tb_top;

   localparam int WINDOW_MAX   = 64;
   localparam int RANDOM_ITEMS = 1630;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [swm_pkg::SAMPLE_W-1:0]    req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [swm_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [swm_pkg::CFG_W-1:0]       csr_data   = '0;

   typedef struct {
      bit [swm_pkg::SAMPLE_W-1:0] median;
      bit                         med_valid;
      bit [swm_pkg::SUM_W-1:0]    total;
      bit                         closing;
   } median_beat_type;

   // A window length of zero behaves as one, anything above the maximum as the maximum.
   function automatic int span_of(bit [swm_pkg::CFG_W-1:0] len);
      if (len == 0)
         return 1;
      if (len > WINDOW_MAX)
         return WINDOW_MAX;
      return int'(len);
   endfunction

   class median_tracker;
      bit [swm_pkg::SAMPLE_W-1:0] ring[WINDOW_MAX];
      bit [swm_pkg::SAMPLE_W-1:0] ordered[WINDOW_MAX];
      int                         fill;
      int                         oldest;
      bit [swm_pkg::SUM_W-1:0]    total;
      bit [swm_pkg::CFG_W-1:0]    window_len = 1;
      median_beat_type            expected_medians[$];
      int                         errors;

      function void set_window(bit [swm_pkg::CFG_W-1:0] len);
         window_len = len;
         fill       = 0;
         oldest     = 0;
      endfunction

      function int pending();
         return expected_medians.size();
      endfunction

      // Drops one copy of the value from the first n sorted entries and returns the new count.
      function int drop_value(int n, bit [swm_pkg::SAMPLE_W-1:0] v);
         int i;
         i = 0;
         while (i < n && ordered[i] != v)
            i++;
         if (i >= n)
            return n;
         for (int j = i; j < n - 1; j++)
            ordered[j] = ordered[j + 1];
         return n - 1;
      endfunction

      // New values go after any equal ones.
      function void place_value(int n, bit [swm_pkg::SAMPLE_W-1:0] v);
         int p;
         p = 0;
         while (p < n && ordered[p] <= v)
            p++;
         for (int j = n; j > p; j--)
            ordered[j] = ordered[j - 1];
         ordered[p] = v;
      endfunction

      function void note_sample(bit [swm_pkg::SAMPLE_W-1:0] s, bit fin);
         int                         k;
         int                         n;
         bit [swm_pkg::SUM_W:0]      wide;
         median_beat_type            beat;
         k = span_of(window_len);
         if (fill > k)
            fill = k;
         if (oldest >= k)
            oldest = 0;
         if (fill < k) begin
            ring[fill] = s;
            place_value(fill, s);
            fill++;
            oldest = 0;
         end else begin
            n = drop_value(k, ring[oldest]);
            place_value(n, s);
            ring[oldest] = s;
            oldest++;
            if (oldest >= k)
               oldest = 0;
         end
         beat.median    = '0;
         beat.med_valid = 1'b0;
         if (fill == k) begin
            beat.med_valid = 1'b1;
            beat.median    = ordered[(k + 1) / 2 - 1];
            wide = {1'b0, total} + (swm_pkg::SUM_W + 1)'(beat.median);
            total = wide[swm_pkg::SUM_W] ? '1 : wide[swm_pkg::SUM_W-1:0];
         end
         beat.total   = total;
         beat.closing = fin;
         expected_medians.push_back(beat);
         if (fin) begin
            fill   = 0;
            oldest = 0;
            total  = '0;
         end
      endfunction

      function void flag(string field, longint unsigned want, longint unsigned got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(median_beat_type got);
         median_beat_type want;
         if (expected_medians.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual median %0d sum %0d",
                     $time, got.median, got.total);
            return;
         end
         want = expected_medians.pop_front();
         if (got.median != want.median)
            flag("median", want.median, got.median);
         if (got.med_valid != want.med_valid)
            flag("median_valid", want.med_valid, got.med_valid);
         if (got.total != want.total)
            flag("median_sum", want.total, got.total);
         if (got.closing != want.closing)
            flag("sum_final", want.closing, got.closing);
      endfunction
   endclass

   median_tracker tracker = new();

   int  cycle_count;
   int  burst_left;
   int  ready_left;
   bit  smooth_flow;

   sliding_window_median_top #(
      .WINDOW_MAX(WINDOW_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      median_beat_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
      if (!reset && req_tvalid && req_tready)
         tracker.note_sample(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.median    = rsp_tdata[swm_pkg::SAMPLE_W-1:0];
         got.total     = rsp_tdata[swm_pkg::RSP_DATA_W-1:swm_pkg::SAMPLE_W];
         got.med_valid = rsp_tuser;
         got.closing   = rsp_tlast;
         tracker.check_result(got);
      end
   end

   // The receiver alternates ready runs with short stalls, unless the phase asks for steady flow.
   always @(negedge clock) begin
      if (smooth_flow) begin
         rsp_tready <= 1'b1;
      end else if (ready_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            ready_left = $urandom_range(1, 8);
         end else begin
            rsp_tready <= 1'b1;
            ready_left = $urandom_range(1, 30);
         end
      end else begin
         ready_left--;
      end
   end

   task automatic send_beat(bit [swm_pkg::SAMPLE_W-1:0] s, bit fin);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= fin;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic drain();
      idle_cycles(1);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_sample(bit [swm_pkg::SAMPLE_W-1:0] s, bit fin);
      if (burst_left == 0) begin
         if ($urandom_range(0, 49) == 0)
            drain();
         else if (!smooth_flow)
            idle_cycles($urandom_range(0, 6));
         burst_left = $urandom_range(1, 24);
      end
      send_beat(s, fin);
      burst_left--;
   endtask

   task automatic program_window(bit [swm_pkg::CFG_W-1:0] len);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do
         @(posedge clock);
      while (!csr_ready);
      tracker.set_window(len);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Small clusters and values near the top make repeated entries common.
   function automatic bit [swm_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return (swm_pkg::SAMPLE_W)'($urandom_range(0, 7));
         1:       return (swm_pkg::SAMPLE_W)'(32'hFFFF - $urandom_range(0, 3));
         4:       return (swm_pkg::SAMPLE_W)'($urandom_range(1000, 1031));
         default: return (swm_pkg::SAMPLE_W)'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int                       sent;
      int                       phase;
      int                       k;
      int                       budget;
      int                       seq_len;
      int                       in_phase;
      bit [swm_pkg::CFG_W-1:0]  len;
      int                       start_lens[6];

      start_lens = '{64, 127, 65, 2, 1, 0};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Window of one after reset: the median is the sample itself.
      push_sample(16'h0000, 1'b0);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'h5555, 1'b0);
      push_sample(16'hAAAA, 1'b1);
      // Repeated values: only one copy of the displaced value leaves the window.
      program_window(3);
      push_sample(5, 1'b0);
      push_sample(5, 1'b0);
      push_sample(9, 1'b0);
      push_sample(5, 1'b0);
      push_sample(2, 1'b1);
      // A sequence closed before the window fills, then a full one.
      program_window(4);
      push_sample(7, 1'b0);
      push_sample(1, 1'b1);
      push_sample(16'hFFFF, 1'b0);
      push_sample(0, 1'b0);
      push_sample(3, 1'b0);
      push_sample(3, 1'b0);
      push_sample(1, 1'b1);
      program_window(0);
      push_sample(100, 1'b0);
      push_sample(200, 1'b1);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase < 6)
            len = (swm_pkg::CFG_W)'(start_lens[phase]);
         else if ($urandom_range(0, 3) == 0)
            len = (swm_pkg::CFG_W)'($urandom_range(0, 127));
         else
            len = (swm_pkg::CFG_W)'($urandom_range(1, 16));
         program_window(len);
         smooth_flow = ($urandom_range(0, 4) == 0);
         k = span_of(len);
         budget = (2 * k + 10 > 130) ? 2 * k + 10 : 130;
         in_phase = 0;
         // Mostly sequences that fill the window; some end early, and the last may run
         // into the next window write unterminated.
         while (in_phase < budget && sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8)
               seq_len = k + $urandom_range(0, 2 * k + 6);
            else
               seq_len = $urandom_range(1, k);
            for (int i = 0; i < seq_len && in_phase < budget && sent < RANDOM_ITEMS; i++) begin
               push_sample(pick_sample(), i == seq_len - 1);
               in_phase++;
               sent++;
            end
         end
         phase++;
      end

      idle_cycles(1);
      smooth_flow = 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
